// ===== design/gpw_pkg.sv =====
package gpw_pkg;

  // Field widths
  localparam int ADDR_BITS    = 25;  // framebuffer address wrap width
  localparam int PIXEL_ADDR_W = 25;  // pixel_address field
  localparam int COORD_W      = 12;
  localparam int CODE_W       = 8;
  localparam int COLOR_W      = 32;
  localparam int STRIDE_W     = 13;
  localparam int BASE_SUM_W   = COORD_W + STRIDE_W + 1;  // y*stride + x
  localparam int GLYPH_ROWS   = 8;
  localparam int GLYPH_COLS   = 8;
  localparam int GLYPH_W      = GLYPH_ROWS * GLYPH_COLS;
  localparam int ROW_W        = $clog2(GLYPH_ROWS);
  localparam int COL_W        = $clog2(GLYPH_COLS);

  // Stream and config port widths
  localparam int IN_TDATA_W   = 2 * COORD_W + CODE_W + 2 * COLOR_W;
  localparam int OUT_FIELDS_W = PIXEL_ADDR_W + COLOR_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = STRIDE_W;

  localparam logic [STRIDE_W-1:0] LINE_WIDTH_RESET = STRIDE_W'(1920);

  // Register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENABLE     = 1'b0,
    REG_LINE_WIDTH = 1'b1
  } cfg_reg_t;

  // One cell handed from the input stage to the raster generator
  typedef struct packed {
    logic [ADDR_BITS-1:0] base;   // address of row 0, column 0
    logic [GLYPH_W-1:0]   glyph;  // row 0 in the top byte, MSB = leftmost pixel
    logic [COLOR_W-1:0]   fore;
    logic [COLOR_W-1:0]   back;
  } gpw_cell_t;

  // 8x8 font: rows concatenated, row 0 first. Undefined glyphs are blank.
  function automatic logic [GLYPH_W-1:0] glyph_bits(input logic [CODE_W-2:0] code);
    logic [GLYPH_W-1:0] bits;
    bits = '0;
    case (code)
      7'h41: bits = 64'h183C66667E666600;  // A
      7'h42: bits = 64'h7C66667C66667C00;  // B
      7'h43: bits = 64'h3C66606060663C00;  // C
      7'h44: bits = 64'h786C6666666C7800;  // D
      7'h45: bits = 64'h7E60607C60607E00;  // E
      7'h46: bits = 64'h7E60607C60606000;  // F
      7'h47: bits = 64'h3C66606E66663C00;  // G
      7'h48: bits = 64'h6666667E66666600;  // H
      7'h49: bits = 64'h3C18181818183C00;  // I
      7'h4F: bits = 64'h3C66666666663C00;  // O
      7'h53: bits = 64'h3C66703C0E663C00;  // S
      7'h56: bits = 64'h66666666663C1800;  // V
      7'h2D: bits = 64'h0000007E00000000;  // -
      7'h69: bits = 64'h1800381818183C00;  // i
      7'h62: bits = 64'h60607C6666667C00;  // b
      default: bits = '0;                  // space and undefined codes
    endcase
    return bits;
  endfunction

endpackage

// ===== design/gpw_raster.sv =====
module gpw_raster
  import gpw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [STRIDE_W-1:0]    line_width,
  // cell load from input stage
  input  logic                   load_valid,
  output logic                   load_ready,
  input  gpw_cell_t              load_cell,
  // pixel write stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  // Generator state
  logic                    busy_r, busy_nxt;
  logic [ADDR_BITS-1:0]    base_r;
  logic [GLYPH_W-1:0]      glyph_r;
  logic [COLOR_W-1:0]      fore_r;
  logic [COLOR_W-1:0]      back_r;
  logic [ROW_W-1:0]        row_r;
  logic [COL_W-1:0]        col_r;

  // Output register
  logic                    ovalid_r, ovalid_nxt;
  logic [PIXEL_ADDR_W-1:0] oaddr_r;
  logic [COLOR_W-1:0]      ocolor_r;
  logic                    olast_r;

  logic emit;
  logic pix_last;
  logic load;

  // One pixel per cycle whenever the output register is free or draining
  assign pix_last   = (&row_r) && (&col_r);
  assign emit       = busy_r && (!ovalid_r || out_tready);
  assign load_ready = !busy_r || (emit && pix_last);
  assign load       = load_valid && load_ready;

  always_comb begin
    busy_nxt = busy_r;
    if (load) begin
      busy_nxt = 1'b1;
    end else if (emit && pix_last) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      row_r    <= '0;
      col_r    <= '0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
      if (load) begin
        row_r <= '0;
        col_r <= '0;
      end else if (emit) begin
        col_r <= col_r + COL_W'(1);
        if (&col_r) begin
          row_r <= row_r + ROW_W'(1);
        end
      end
    end
  end

  // Cell payload; row base steps by the stride at each row end
  always_ff @(posedge clk) begin
    if (load) begin
      base_r  <= load_cell.base;
      glyph_r <= load_cell.glyph;
      fore_r  <= load_cell.fore;
      back_r  <= load_cell.back;
    end else if (emit) begin
      glyph_r <= glyph_r << 1;
      if (&col_r) begin
        base_r <= base_r + ADDR_BITS'(line_width);
      end
    end
  end

  // Pixel write register
  always_ff @(posedge clk) begin
    if (emit) begin
      oaddr_r  <= PIXEL_ADDR_W'(base_r + ADDR_BITS'(col_r));
      ocolor_r <= glyph_r[GLYPH_W-1] ? fore_r : back_r;
      olast_r  <= pix_last;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, ocolor_r, oaddr_r};

endmodule

// ===== design/glyph_pixel_writer.sv =====
// Channel  Direction  Transaction                 Payload
// in_      slave      one character cell          x, y, char_code, fore, back
// out_     master     one pixel write             pixel_address, pixel_color, last
// cfg_     slave      one register write          index, data
//
// Each enabled cell gives 64 pixel writes, one per cycle while out_tready is high;
// the raster generator's single pixel port sets that rate. The next cell loads into
// the generator in the cycle its predecessor's last pixel is emitted, so cells
// stream without gaps. Cells reach out_ via the input, generator and output
// registers. Reset disables the block and sets the stride to 1920. A stalled
// out_tready holds the generator; the input register then holds one waiting cell.
module glyph_pixel_writer
  import gpw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: cell_x[11:0], cell_y[23:12], char_code[31:24],
  //           fore_color[63:32], back_color[95:64]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: pixel_address[24:0], pixel_color[56:25], zero fill above
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic                enable_r;
  logic [STRIDE_W-1:0] line_width_r;

  // Input register
  logic                     avalid_r, avalid_nxt;
  logic [COORD_W-1:0]       ax_r;
  logic [COORD_W-1:0]       ay_r;
  logic signed [CODE_W-1:0] acode_r;
  logic [COLOR_W-1:0]       afore_r;
  logic [COLOR_W-1:0]       aback_r;

  logic                  in_fire;
  logic                  a_take;
  logic                  load_ready;
  logic [BASE_SUM_W-1:0] base_sum;
  gpw_cell_t             ld_cell;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      line_width_r <= LINE_WIDTH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE:     enable_r     <= cfg_data[0];
        REG_LINE_WIDTH: line_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage: cells arriving while disabled are taken and dropped
  assign a_take    = avalid_r && load_ready;
  assign in_tready = !avalid_r || a_take;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    avalid_nxt = avalid_r;
    if (in_fire && enable_r) begin
      avalid_nxt = 1'b1;
    end else if (a_take) begin
      avalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avalid_r <= 1'b0;
    end else begin
      avalid_r <= avalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ax_r    <= in_tdata[COORD_W-1:0];
      ay_r    <= in_tdata[2*COORD_W-1:COORD_W];
      acode_r <= in_tdata[2*COORD_W+CODE_W-1:2*COORD_W];
      afore_r <= in_tdata[2*COORD_W+CODE_W+COLOR_W-1:2*COORD_W+CODE_W];
      aback_r <= in_tdata[IN_TDATA_W-1:2*COORD_W+CODE_W+COLOR_W];
    end
  end

  // Cell origin address and font lookup; negative codes draw as blank space
  assign base_sum      = BASE_SUM_W'(ay_r) * BASE_SUM_W'(line_width_r) + BASE_SUM_W'(ax_r);
  assign ld_cell.base  = ADDR_BITS'(base_sum);
  assign ld_cell.glyph = acode_r[CODE_W-1] ? '0 : glyph_bits(acode_r[CODE_W-2:0]);
  assign ld_cell.fore  = afore_r;
  assign ld_cell.back  = aback_r;

  gpw_raster u_raster (
    .clk        (clk),
    .rst_n      (rst_n),
    .line_width (line_width_r),
    .load_valid (avalid_r),
    .load_ready (load_ready),
    .load_cell  (ld_cell),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/sv/glyph_pixel_writer_tb.sv =====
module glyph_pixel_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gpw_pkg::*;

  // One cell request; the packed order matches in_tdata, x in the low bits
  typedef struct packed {
    logic [COLOR_W-1:0] back;
    logic [COLOR_W-1:0] fore;
    logic [CODE_W-1:0]  code;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } cell_t;

  // One pixel write as it leaves the block
  typedef struct packed {
    logic [PIXEL_ADDR_W-1:0] addr;
    logic [COLOR_W-1:0]      color;
    logic                    last;
  } pixel_t;

  typedef enum bit {ROW_CFG, ROW_CELL} row_kind_t;

  // Directed row: either a register write or a cell; all_back marks cells
  // whose every pixel must come out in the background color.
  typedef struct {
    row_kind_t          kind;
    cfg_reg_t           idx;
    logic [STRIDE_W-1:0] val;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CODE_W-1:0]  code;
    logic [COLOR_W-1:0] fore;
    logic [COLOR_W-1:0] back;
    bit                 all_back;
  } dir_row_t;

  // Random phase: register setting, item count, idle rates, hold-off
  typedef struct {
    bit en;
    int lw;
    int items;
    int in_idle;
    int out_idle;
    int hold;
  } phase_t;

  localparam int LW_RANDOM = -1;
  localparam int SETTLE    = 16;   // cycles past the last write before idle
  localparam int N_DIR     = 31;
  localparam int N_PHASE   = 7;
  localparam int N_GLYPH   = 15;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Shadow registers and expected pixel writes
  bit                  en_q     = 1'b0;
  logic [STRIDE_W-1:0] stride_q = 13'd1920;
  pixel_t              pixel_q[$];
  int                  mismatch_cnt = 0;
  int                  in_idle_pct  = 31;
  int                  out_idle_pct = 31;
  int                  hold_len     = 0;

  logic [7:0] font_rom [128][8];
  logic [7:0] glyph_codes [N_GLYPH] = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
                                        8'h48, 8'h49, 8'h4F, 8'h53, 8'h56, 8'h2D, 8'h69,
                                        8'h62};

  // kind, reg, value, x, y, code, fore, back, all_back
  dir_row_t dir_rows [N_DIR] = '{
    // reset state: disabled, nothing comes out
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd5, 12'd3, 8'h41, 32'h1, 32'h0, 1'b0},
    '{ROW_CFG, REG_ENABLE, 13'h0001, 12'd0, 12'd0, 8'h0, 32'h0, 32'h0, 1'b0},
    // every glyph of the font at the reset stride
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd0, 12'd0, 8'h41, 32'hFFFFFFFF, 32'h0, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd8, 12'd0, 8'h42, 32'h12345678, 32'h9ABCDEF0, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd16, 12'd0, 8'h43, 32'hA5A5A5A5, 32'h5A5A5A5A, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd24, 12'd0, 8'h44, 32'h00FF00FF, 32'hFF00FF00, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd32, 12'd8, 8'h45, 32'h11111111, 32'h22222222, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd40, 12'd8, 8'h46, 32'h33333333, 32'h44444444, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd48, 12'd8, 8'h47, 32'h55555555, 32'h66666666, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd56, 12'd16, 8'h48, 32'h77777777, 32'h88888888, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd100, 12'd200, 8'h49, 32'hDEADBEEF, 32'h0, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd1000, 12'd300, 8'h4F, 32'hCAFEF00D, 32'h1, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd2000, 12'd1000, 8'h53, 32'h0F0F0F0F, 32'hF0F0F0F0, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd3000, 12'd2000, 8'h56, 32'h80000000, 32'h7FFFFFFF, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd4088, 12'd4088, 8'h2D, 32'hFFFF0000, 32'h0000FFFF, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd7, 12'd9, 8'h69, 32'h01234567, 32'h89ABCDEF, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd1234, 12'd567, 8'h62, 32'hFEDCBA98, 32'h76543210, 1'b0},
    // space, negative codes and an undefined glyph are all background
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd64, 12'd64, 8'h20, 32'hFFFFFFFF, 32'h0BADC0DE, 1'b1},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd72, 12'd64, 8'h80, 32'hFFFFFFFF, 32'h13572468, 1'b1},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd80, 12'd64, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFE, 1'b1},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd88, 12'd64, 8'h7F, 32'hFFFFFFFF, 32'h00000000, 1'b1},
    // stride extremes, cells off the far corner wrap
    '{ROW_CFG, REG_LINE_WIDTH, 13'd4096, 12'd0, 12'd0, 8'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'hFFF, 12'hFFF, 8'h53, 32'hFFFFFFFF, 32'h0, 1'b0},
    '{ROW_CFG, REG_LINE_WIDTH, 13'd0, 12'd0, 12'd0, 8'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd10, 12'd10, 8'h48, 32'h0000AAAA, 32'h5555, 1'b0},
    '{ROW_CFG, REG_LINE_WIDTH, 13'h1FFF, 12'd0, 12'd0, 8'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'hFFF, 12'hFFF, 8'h41, 32'h0, 32'hFFFFFFFF, 1'b0},
    '{ROW_CFG, REG_LINE_WIDTH, 13'd1, 12'd0, 12'd0, 8'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'd0, 12'hFFF, 8'h56, 32'h12121212, 32'h34343434, 1'b0},
    // enable takes bit 0 only: this write disables, the cell gives nothing
    '{ROW_CFG, REG_ENABLE, 13'h1FFE, 12'd0, 12'd0, 8'h0, 32'h0, 32'h0, 1'b0},
    '{ROW_CELL, REG_ENABLE, 13'd0, 12'hFFF, 12'hFFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0}
  };

  // en, line width, items, sender idle %, receiver idle %, hold-off cycles
  phase_t phases [N_PHASE] = '{
    '{1'b1, LW_RANDOM, 30, 31, 31, 0},
    '{1'b1, 1,         30, 31, 31, 300},
    '{1'b0, LW_RANDOM, 10, 31, 31, 0},
    '{1'b1, 4096,      30, 0,  0,  0},
    '{1'b1, 0,         20, 31, 31, 0},
    '{1'b1, 8191,      30, 31, 31, 0},
    '{1'b1, LW_RANDOM, 35, 31, 31, 0}
  };

  glyph_pixel_writer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Font: rows top to bottom, MSB is the leftmost pixel
  initial begin
    foreach (font_rom[c, r]) font_rom[c][r] = 8'h00;
    font_rom[8'h41] = '{8'h18, 8'h3C, 8'h66, 8'h66, 8'h7E, 8'h66, 8'h66, 8'h00};
    font_rom[8'h42] = '{8'h7C, 8'h66, 8'h66, 8'h7C, 8'h66, 8'h66, 8'h7C, 8'h00};
    font_rom[8'h43] = '{8'h3C, 8'h66, 8'h60, 8'h60, 8'h60, 8'h66, 8'h3C, 8'h00};
    font_rom[8'h44] = '{8'h78, 8'h6C, 8'h66, 8'h66, 8'h66, 8'h6C, 8'h78, 8'h00};
    font_rom[8'h45] = '{8'h7E, 8'h60, 8'h60, 8'h7C, 8'h60, 8'h60, 8'h7E, 8'h00};
    font_rom[8'h46] = '{8'h7E, 8'h60, 8'h60, 8'h7C, 8'h60, 8'h60, 8'h60, 8'h00};
    font_rom[8'h47] = '{8'h3C, 8'h66, 8'h60, 8'h6E, 8'h66, 8'h66, 8'h3C, 8'h00};
    font_rom[8'h48] = '{8'h66, 8'h66, 8'h66, 8'h7E, 8'h66, 8'h66, 8'h66, 8'h00};
    font_rom[8'h49] = '{8'h3C, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h3C, 8'h00};
    font_rom[8'h4F] = '{8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C, 8'h00};
    font_rom[8'h53] = '{8'h3C, 8'h66, 8'h70, 8'h3C, 8'h0E, 8'h66, 8'h3C, 8'h00};
    font_rom[8'h56] = '{8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C, 8'h18, 8'h00};
    font_rom[8'h2D] = '{8'h00, 8'h00, 8'h00, 8'h7E, 8'h00, 8'h00, 8'h00, 8'h00};
    font_rom[8'h69] = '{8'h18, 8'h00, 8'h38, 8'h18, 8'h18, 8'h18, 8'h3C, 8'h00};
    font_rom[8'h62] = '{8'h60, 8'h60, 8'h7C, 8'h66, 8'h66, 8'h66, 8'h7C, 8'h00};
  end

  // Expands an accepted cell into its 64 expected pixel writes, none while disabled
  task automatic render_cell(input cell_t c, input bit all_back);
    logic [6:0]  glyph;
    logic [7:0]  bits;
    logic [63:0] row_base;
    pixel_t      px;
    if (!en_q) return;
    glyph = c.code[7] ? 7'h20 : c.code[6:0];
    for (int r = 0; r < 8; r++) begin
      bits     = font_rom[glyph][r];
      row_base = (64'(c.y) + 64'(r)) * 64'(stride_q) + 64'(c.x);
      for (int k = 0; k < 8; k++) begin
        px.addr  = PIXEL_ADDR_W'(row_base + 64'(k));
        px.color = (bits[7-k] && !all_back) ? c.fore : c.back;
        px.last  = (r == 7 && k == 7);
        pixel_q.push_back(px);
      end
    end
  endtask

  // Offers one cell, with random idle cycles ahead of it; starts and ends at negedge
  task automatic send_cell(input cell_t c, input bit all_back);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom, $urandom};
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    render_cell(c, all_back);
    @(negedge clk);
  endtask

  // Register write; only called with the block idle
  task automatic write_reg(input cfg_reg_t idx, input logic [STRIDE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_ENABLE) en_q = val[0];
    else stride_q = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering cells and wait until every expected write is out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pixel_q.size() != 0 || hold_len != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic cell_t random_cell();
    cell_t c;
    int    pick;
    c.fore = $urandom;
    c.back = $urandom;
    pick   = $urandom_range(9);
    c.x    = (pick == 0) ? 12'hFFF : (pick == 1) ? 12'h000 : 12'($urandom);
    pick   = $urandom_range(9);
    c.y    = (pick == 0) ? 12'hFFF : (pick == 1) ? 12'h000 : 12'($urandom);
    pick   = $urandom_range(9);
    if (pick < 6) c.code = glyph_codes[$urandom_range(N_GLYPH - 1)];
    else if (pick < 8) c.code = 8'($urandom);
    else if (pick == 8) c.code = 8'h20;
    else c.code = 8'h80 | 8'($urandom);
    return c;
  endfunction

  // Receiver: random back-pressure, plus a counted hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        hold_len--;
      end else begin
        out_tready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Compare each pixel write transaction with the oldest expectation
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel write: address %h color %h",
               out_tdata[PIXEL_ADDR_W-1:0], out_tdata[PIXEL_ADDR_W +: COLOR_W]);
        mismatch_cnt++;
      end else begin
        want = pixel_q.pop_front();
        if (out_tdata[PIXEL_ADDR_W-1:0] !== want.addr) begin
          $error("pixel_address: expected %h, got %h", want.addr,
                 out_tdata[PIXEL_ADDR_W-1:0]);
          mismatch_cnt++;
        end
        if (out_tdata[PIXEL_ADDR_W +: COLOR_W] !== want.color) begin
          $error("pixel_color: expected %h, got %h", want.color,
                 out_tdata[PIXEL_ADDR_W +: COLOR_W]);
          mismatch_cnt++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    cell_t c;
    int    lw;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ENABLE;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        c.x    = dir_rows[i].x;
        c.y    = dir_rows[i].y;
        c.code = dir_rows[i].code;
        c.fore = dir_rows[i].fore;
        c.back = dir_rows[i].back;
        send_cell(c, dir_rows[i].all_back);
      end
    end

    // random phases, each under its own register setting
    foreach (phases[p]) begin
      drain();
      lw = (phases[p].lw == LW_RANDOM) ? $urandom_range(4096, 1) : phases[p].lw;
      write_reg(REG_ENABLE, {12'($urandom), phases[p].en});
      write_reg(REG_LINE_WIDTH, STRIDE_W'(lw));
      in_idle_pct  = phases[p].in_idle;
      out_idle_pct = phases[p].out_idle;
      hold_len     = phases[p].hold;
      repeat (phases[p].items) send_cell(random_cell(), 1'b0);
    end

    drain();
    if (mismatch_cnt == 0 && pixel_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
